// ===== rtl/mlsa_pkg.sv =====
// Shared constants, code types and saturation helpers for the mel log spectrum
// synthesis filter and its delay memory.
// No dependencies.
package mlsa_pkg;

    localparam int ORDER       = 24;
    localparam int MAX_STAGES  = 8;
    localparam int DELAY_DEPTH = 256;

    localparam int FB      = 20;
    localparam int KB      = 24;
    localparam int SMP_W   = 24;
    localparam int D_W     = 32;
    localparam int ACC_W   = 42;
    localparam int MUL_W   = 33;
    localparam int ALPHA_W = 21;
    localparam int AA_W    = 22;
    localparam int K_W     = 24;

    localparam int RAM_AW        = $clog2(DELAY_DEPTH);
    localparam int ADDR_MAX_MLSA = 17 + 5 * (ORDER + 2);
    localparam int ADDR_MAX_MGL  = MAX_STAGES * (ORDER + 1);
    localparam int ADDR_MAX      = (ADDR_MAX_MLSA > ADDR_MAX_MGL) ? ADDR_MAX_MLSA
                                                                   : ADDR_MAX_MGL;
    localparam int IDX_RAW_W     = $clog2(ADDR_MAX + 1);
    localparam int IDX_W         = (IDX_RAW_W > RAM_AW) ? IDX_RAW_W : RAM_AW;
    localparam int CI_W          = $clog2(ORDER + 1);
    localparam int SEC_W         = ($clog2(MAX_STAGES + 1) > 3) ? $clog2(MAX_STAGES + 1) : 3;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 21;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_KIND = 3'd0,
        CFG_WARP_ALPHA  = 3'd1,
        CFG_PADE_ORDER  = 3'd2,
        CFG_STAGE_COUNT = 3'd3,
        CFG_ORDER_USE   = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_FILTER = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    function automatic logic signed [D_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -ACC_W'(64'sd2147483648);
        if (v > hi)
            return D_W'(hi);
        else if (v < lo)
            return D_W'(lo);
        else
            return D_W'(v);
    endfunction

    // Pade constants, Q0.24
    function automatic logic [K_W-1:0] pade_k(input logic pd5, input logic [2:0] i);
        logic [K_W-1:0] k;
        case (i)
            3'd1:    k = pd5 ? 24'd8387586 : 24'd8387388;
            3'd2:    k = pd5 ? 24'd1857402 : 24'd1790137;
            3'd3:    k = pd5 ? 24'd229845  : 24'd196331;
            3'd4:    k = pd5 ? 24'd16047   : 24'd9490;
            3'd5:    k = pd5 ? 24'd510     : 24'd0;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/mlsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== rtl/mel_log_spectrum_synthesis_filter.sv =====
// Top level of the mel log spectrum synthesis filter: sequencer, shared multiplier,
// coefficient registers and delay memory valid bits.
// Depends on mlsa_pkg and mlsa_ram.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | in_valid / in_ready    | func, coef_index, coef_value, sample_in
//  output   | out_valid / out_ready  | sample_out, saturated
//  config   | cfg_we                 | cfg_index, cfg_data
//
// Load, clear and unused codes are handled in the idle state without starting
// the sequencer. A filter transaction runs at most one multiply per step through
// the shared multiplier and the delay RAM, which has one write and one read port,
// for both MLSA and MGLSA. in_ready is high only while idle; a finished result
// waits in the output register, and the sequencer stalls in its final step only
// when that register is still full and out_ready is low. Clear is immediate via
// per-entry valid bits, no sweep after reset.
module mel_log_spectrum_synthesis_filter
    import mlsa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 func,
    input  logic [4:0]                 coef_index,
    input  logic signed [SMP_W-1:0]    coef_value,
    input  logic signed [SMP_W-1:0]    sample_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SMP_W-1:0]    sample_out,
    output logic                       saturated,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    localparam int STATE_W = 38;

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE    = STATE_W'(1) << 0,
        ST_AA      = STATE_W'(1) << 1,
        ST_AA2     = STATE_W'(1) << 2,
        ST_F1_RD0  = STATE_W'(1) << 3,
        ST_F1_RD1  = STATE_W'(1) << 4,
        ST_F1_M0   = STATE_W'(1) << 5,
        ST_F1_M1   = STATE_W'(1) << 6,
        ST_F1_W0   = STATE_W'(1) << 7,
        ST_F1_M2   = STATE_W'(1) << 8,
        ST_F1_W1   = STATE_W'(1) << 9,
        ST_F1_M3   = STATE_W'(1) << 10,
        ST_F1_ACC  = STATE_W'(1) << 11,
        ST_F1_END  = STATE_W'(1) << 12,
        ST_S2_RD   = STATE_W'(1) << 13,
        ST_S2_W0   = STATE_W'(1) << 14,
        ST_S2_RD1  = STATE_W'(1) << 15,
        ST_S2_M1   = STATE_W'(1) << 16,
        ST_S2_W1   = STATE_W'(1) << 17,
        ST_WL_RD0  = STATE_W'(1) << 18,
        ST_WL_RD1  = STATE_W'(1) << 19,
        ST_WL_M0   = STATE_W'(1) << 20,
        ST_WL_W    = STATE_W'(1) << 21,
        ST_WL_M1   = STATE_W'(1) << 22,
        ST_WL_ACC  = STATE_W'(1) << 23,
        ST_SH_RD   = STATE_W'(1) << 24,
        ST_SH_W    = STATE_W'(1) << 25,
        ST_S2_FD   = STATE_W'(1) << 26,
        ST_S2_M3   = STATE_W'(1) << 27,
        ST_S2_ACC  = STATE_W'(1) << 28,
        ST_S2_END  = STATE_W'(1) << 29,
        ST_P_START = STATE_W'(1) << 30,
        ST_P_M0    = STATE_W'(1) << 31,
        ST_P_M0B   = STATE_W'(1) << 32,
        ST_P_X     = STATE_W'(1) << 33,
        ST_P_M1    = STATE_W'(1) << 34,
        ST_P_M2    = STATE_W'(1) << 35,
        ST_P_W     = STATE_W'(1) << 36,
        ST_DONE    = STATE_W'(1) << 37
    } state_t;

    state_t state_reg, state_next;

    logic                     filter_kind_reg;
    logic signed [ALPHA_W-1:0] warp_alpha_reg;
    logic [2:0]               pade_order_reg;
    logic [3:0]               stage_count_reg;
    logic [4:0]               order_in_use_reg;

    logic signed [SMP_W-1:0]  coef_reg [ORDER+1];
    logic [DELAY_DEPTH-1:0]   valid_reg;

    logic signed [AA_W-1:0]   aa_reg, aa_next;
    logic signed [ACC_W-1:0]  x_reg, x_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  y_reg, y_next;
    logic signed [D_W-1:0]    t_reg, t_next;
    logic signed [D_W-1:0]    prev_reg, prev_next;
    logic [SEC_W-1:0]         sec_reg, sec_next;
    logic [IDX_W-1:0]         ptr_reg, ptr_next;
    logic [IDX_W-1:0]         fb_reg, fb_next;
    logic [IDX_W-1:0]         pt2_reg, pt2_next;
    logic [CI_W-1:0]          ci_reg, ci_next;
    logic [CI_W-1:0]          cnt_reg, cnt_next;
    logic [CI_W-1:0]          m_reg, m_next;
    logic                     pd5_reg, pd5_next;
    logic [SEC_W-1:0]         n_reg, n_next;
    logic signed [ACC_W-1:0]  prod_reg;

    logic                     out_valid_reg, out_valid_next;
    logic signed [SMP_W-1:0]  sample_out_reg, sample_out_next;
    logic                     saturated_reg, saturated_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic                     mul_k;
    logic signed [2*MUL_W-1:0] prod_full, prod_rnd;
    logic signed [ACC_W-1:0]  prod_next;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [ACC_W-1:0]  wr_val;
    logic signed [D_W-1:0]    wr_data;
    logic                     ram_we;
    logic [IDX_W-1:0]         rd_addr;
    logic [D_W-1:0]           ram_q;
    logic                     rd_ok_reg;
    logic signed [D_W-1:0]    rdv;

    logic                     in_acc;
    logic [CI_W-1:0]          coef_sel;
    logic signed [SMP_W-1:0]  b_val;
    logic [IDX_W-1:0]         mp2;
    logic [IDX_W-1:0]         pt1;
    logic signed [MUL_W-1:0]  k_val;
    logic signed [ACC_W-1:0]  wv;
    logic signed [ACC_W-1:0]  x_sat_hi, x_sat_lo;

    function automatic logic in_range(input logic [IDX_W-1:0] addr);
        return 32'(addr) < DELAY_DEPTH;
    endfunction

    function automatic logic signed [D_W-1:0] fwd(input logic [IDX_W-1:0] addr,
                                                  input logic signed [ACC_W-1:0] v);
        return in_range(addr) ? sat32(v) : '0;
    endfunction

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;

    assign coef_sel = ((state_reg == ST_F1_M2) || (state_reg == ST_P_M0)) ? CI_W'(1) : ci_reg;
    assign b_val    = coef_reg[coef_sel];
    assign mp2      = IDX_W'(m_reg) + IDX_W'(2);
    assign pt1      = pd5_reg ? IDX_W'(6) : IDX_W'(5);
    assign k_val    = $signed({{(MUL_W-K_W){1'b0}}, pade_k(pd5_reg, sec_reg[2:0])});
    assign rdv      = rd_ok_reg ? $signed(ram_q) : '0;
    assign x_sat_hi = ACC_W'(64'sd8388607);
    assign x_sat_lo = -ACC_W'(64'sd8388608);

    // shared multiplier, round to nearest
    assign prod_full = mul_a * mul_b;
    assign prod_rnd  = mul_k ? ((prod_full + (2*MUL_W)'(64'sd1 << (KB - 1))) >>> KB)
                             : ((prod_full + (2*MUL_W)'(64'sd1 << (FB - 1))) >>> FB);
    assign prod_next = ACC_W'(prod_rnd);

    assign wr_data = sat32(wr_val);
    assign ram_we  = wr_en && in_range(wr_addr);

    mlsa_ram #(
        .WIDTH (D_W),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr[RAM_AW-1:0]),
        .wdata (wr_data),
        .raddr (rd_addr[RAM_AW-1:0]),
        .rdata (ram_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        aa_next         = aa_reg;
        x_next          = x_reg;
        acc_next        = acc_reg;
        y_next          = y_reg;
        t_next          = t_reg;
        prev_next       = prev_reg;
        sec_next        = sec_reg;
        ptr_next        = ptr_reg;
        fb_next         = fb_reg;
        pt2_next        = pt2_reg;
        ci_next         = ci_reg;
        cnt_next        = cnt_reg;
        m_next          = m_reg;
        pd5_next        = pd5_reg;
        n_next          = n_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        sample_out_next = sample_out_reg;
        saturated_next  = saturated_reg;
        mul_a           = '0;
        mul_b           = '0;
        mul_k           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_val          = '0;
        rd_addr         = '0;
        wv              = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (func == FUNC_FILTER))
                begin
                    x_next   = ACC_W'(sample_in);
                    pd5_next = (pade_order_reg >= 3'd5);
                    if (order_in_use_reg == 5'd0)
                        m_next = CI_W'(1);
                    else if (32'(order_in_use_reg) > ORDER)
                        m_next = CI_W'(ORDER);
                    else
                        m_next = CI_W'(order_in_use_reg);
                    if (stage_count_reg == 4'd0)
                        n_next = SEC_W'(1);
                    else if (32'(stage_count_reg) > MAX_STAGES)
                        n_next = SEC_W'(MAX_STAGES);
                    else
                        n_next = SEC_W'(stage_count_reg);
                    state_next = ST_AA;
                end
            end
            ST_AA:
            begin
                mul_a      = MUL_W'(warp_alpha_reg);
                mul_b      = MUL_W'(warp_alpha_reg);
                state_next = ST_AA2;
            end
            ST_AA2:
            begin
                aa_next  = AA_W'(64'sd1 << FB) - AA_W'(prod_reg);
                pt2_next = IDX_W'(pt1 << 1) + IDX_W'(mp2 << 2) + (pd5_reg ? mp2 : '0);
                acc_next = '0;
                if (!filter_kind_reg)
                begin
                    sec_next   = pd5_reg ? SEC_W'(5) : SEC_W'(4);
                    state_next = ST_F1_RD0;
                end
                else
                begin
                    sec_next   = '0;
                    fb_next    = '0;
                    state_next = ST_P_START;
                end
            end
            ST_F1_RD0:
            begin
                rd_addr    = pt1 + IDX_W'(sec_reg) - IDX_W'(1);
                state_next = ST_F1_RD1;
            end
            ST_F1_RD1:
            begin
                rd_addr    = IDX_W'(sec_reg);
                t_next     = rdv;
                state_next = ST_F1_M0;
            end
            ST_F1_M0:
            begin
                mul_a      = MUL_W'(aa_reg);
                mul_b      = MUL_W'(t_reg);
                prev_next  = rdv;
                state_next = ST_F1_M1;
            end
            ST_F1_M1:
            begin
                mul_a      = MUL_W'(warp_alpha_reg);
                mul_b      = MUL_W'(prev_reg);
                y_next     = prod_reg;
                state_next = ST_F1_W0;
            end
            ST_F1_W0:
            begin
                wv         = y_reg + prod_reg;
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(sec_reg);
                wr_val     = wv;
                t_next     = fwd(IDX_W'(sec_reg), wv);
                state_next = ST_F1_M2;
            end
            ST_F1_M2:
            begin
                mul_a      = MUL_W'(t_reg);
                mul_b      = MUL_W'(b_val);
                state_next = ST_F1_W1;
            end
            ST_F1_W1:
            begin
                wr_en      = 1'b1;
                wr_addr    = pt1 + IDX_W'(sec_reg);
                wr_val     = prod_reg;
                t_next     = fwd(pt1 + IDX_W'(sec_reg), prod_reg);
                state_next = ST_F1_M3;
            end
            ST_F1_M3:
            begin
                mul_a      = MUL_W'(t_reg);
                mul_b      = k_val;
                mul_k      = 1'b1;
                state_next = ST_F1_ACC;
            end
            ST_F1_ACC:
            begin
                x_next   = sec_reg[0] ? (x_reg + prod_reg) : (x_reg - prod_reg);
                acc_next = acc_reg + prod_reg;
                if (sec_reg == SEC_W'(1))
                    state_next = ST_F1_END;
                else
                begin
                    sec_next   = sec_reg - SEC_W'(1);
                    state_next = ST_F1_RD0;
                end
            end
            ST_F1_END:
            begin
                wr_en      = 1'b1;
                wr_addr    = pt1;
                wr_val     = x_reg;
                x_next     = ACC_W'(sat32(acc_reg + x_reg));
                acc_next   = '0;
                sec_next   = pd5_reg ? SEC_W'(5) : SEC_W'(4);
                fb_next    = pt2_reg - mp2;
                state_next = ST_S2_RD;
            end
            ST_S2_RD:
            begin
                rd_addr    = pt2_reg + IDX_W'(sec_reg) - IDX_W'(1);
                state_next = ST_S2_W0;
            end
            ST_S2_W0:
            begin
                wr_en      = 1'b1;
                wr_addr    = fb_reg;
                wr_val     = ACC_W'(rdv);
                prev_next  = fwd(fb_reg, ACC_W'(rdv));
                state_next = ST_S2_RD1;
            end
            ST_S2_RD1:
            begin
                rd_addr    = fb_reg + IDX_W'(1);
                mul_a      = MUL_W'(aa_reg);
                mul_b      = MUL_W'(prev_reg);
                state_next = ST_S2_M1;
            end
            ST_S2_M1:
            begin
                mul_a      = MUL_W'(warp_alpha_reg);
                mul_b      = MUL_W'(rdv);
                y_next     = prod_reg;
                state_next = ST_S2_W1;
            end
            ST_S2_W1:
            begin
                wv        = y_reg + prod_reg;
                wr_en     = 1'b1;
                wr_addr   = fb_reg + IDX_W'(1);
                wr_val    = wv;
                prev_next = fwd(fb_reg + IDX_W'(1), wv);
                y_next    = '0;
                ptr_next  = fb_reg + IDX_W'(2);
                ci_next   = CI_W'(2);
                if (m_reg == CI_W'(1))
                begin
                    cnt_next   = CI_W'(1);
                    state_next = ST_SH_RD;
                end
                else
                begin
                    cnt_next   = m_reg - CI_W'(1);
                    state_next = ST_WL_RD0;
                end
            end
            ST_WL_RD0:
            begin
                rd_addr    = ptr_reg;
                state_next = ST_WL_RD1;
            end
            ST_WL_RD1:
            begin
                rd_addr    = ptr_reg + IDX_W'(1);
                t_next     = rdv;
                state_next = ST_WL_M0;
            end
            ST_WL_M0:
            begin
                mul_a      = MUL_W'(warp_alpha_reg);
                mul_b      = MUL_W'(rdv) - MUL_W'(prev_reg);
                state_next = ST_WL_W;
            end
            ST_WL_W:
            begin
                wv         = ACC_W'(t_reg) + prod_reg;
                wr_en      = 1'b1;
                wr_addr    = ptr_reg;
                wr_val     = wv;
                t_next     = fwd(ptr_reg, wv);
                prev_next  = fwd(ptr_reg, wv);
                state_next = ST_WL_M1;
            end
            ST_WL_M1:
            begin
                mul_a      = MUL_W'(t_reg);
                mul_b      = MUL_W'(b_val);
                state_next = ST_WL_ACC;
            end
            ST_WL_ACC:
            begin
                y_next = y_reg + prod_reg;
                if (cnt_reg == CI_W'(1))
                begin
                    ptr_next   = fb_reg + IDX_W'(m_reg) + (filter_kind_reg ? '0 : IDX_W'(1));
                    cnt_next   = m_reg;
                    state_next = ST_SH_RD;
                end
                else
                begin
                    ptr_next   = ptr_reg + IDX_W'(1);
                    ci_next    = ci_reg + CI_W'(1);
                    cnt_next   = cnt_reg - CI_W'(1);
                    state_next = ST_WL_RD0;
                end
            end
            ST_SH_RD:
            begin
                rd_addr    = ptr_reg - IDX_W'(1);
                state_next = ST_SH_W;
            end
            ST_SH_W:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_val  = ACC_W'(rdv);
                if (cnt_reg == CI_W'(1))
                    state_next = filter_kind_reg ? ST_P_X : ST_S2_FD;
                else
                begin
                    ptr_next   = ptr_reg - IDX_W'(1);
                    cnt_next   = cnt_reg - CI_W'(1);
                    state_next = ST_SH_RD;
                end
            end
            ST_S2_FD:
            begin
                wr_en      = 1'b1;
                wr_addr    = pt2_reg + IDX_W'(sec_reg);
                wr_val     = y_reg;
                t_next     = fwd(pt2_reg + IDX_W'(sec_reg), y_reg);
                state_next = ST_S2_M3;
            end
            ST_S2_M3:
            begin
                mul_a      = MUL_W'(t_reg);
                mul_b      = k_val;
                mul_k      = 1'b1;
                state_next = ST_S2_ACC;
            end
            ST_S2_ACC:
            begin
                x_next   = sec_reg[0] ? (x_reg + prod_reg) : (x_reg - prod_reg);
                acc_next = acc_reg + prod_reg;
                if (sec_reg == SEC_W'(1))
                    state_next = ST_S2_END;
                else
                begin
                    sec_next   = sec_reg - SEC_W'(1);
                    fb_next    = fb_reg - mp2;
                    state_next = ST_S2_RD;
                end
            end
            ST_S2_END:
            begin
                wr_en      = 1'b1;
                wr_addr    = pt2_reg;
                wr_val     = x_reg;
                x_next     = acc_reg + x_reg;
                state_next = ST_DONE;
            end
            ST_P_START:
            begin
                rd_addr    = fb_reg;
                state_next = ST_P_M0;
            end
            ST_P_M0:
            begin
                mul_a      = MUL_W'(rdv);
                mul_b      = MUL_W'(b_val);
                prev_next  = rdv;
                state_next = ST_P_M0B;
            end
            ST_P_M0B:
            begin
                y_next   = prod_reg;
                ptr_next = fb_reg + IDX_W'(1);
                ci_next  = CI_W'(2);
                if (m_reg == CI_W'(1))
                begin
                    cnt_next   = CI_W'(1);
                    state_next = ST_SH_RD;
                end
                else
                begin
                    cnt_next   = m_reg - CI_W'(1);
                    state_next = ST_WL_RD0;
                end
            end
            ST_P_X:
            begin
                x_next     = ACC_W'(sat32(x_reg - y_reg));
                rd_addr    = fb_reg;
                state_next = ST_P_M1;
            end
            ST_P_M1:
            begin
                mul_a      = MUL_W'(warp_alpha_reg);
                mul_b      = MUL_W'(rdv);
                state_next = ST_P_M2;
            end
            ST_P_M2:
            begin
                mul_a      = MUL_W'(aa_reg);
                mul_b      = MUL_W'(x_reg);
                y_next     = prod_reg;
                state_next = ST_P_W;
            end
            ST_P_W:
            begin
                wr_en   = 1'b1;
                wr_addr = fb_reg;
                wr_val  = y_reg + prod_reg;
                if (sec_reg == n_reg - SEC_W'(1))
                    state_next = ST_DONE;
                else
                begin
                    sec_next   = sec_reg + SEC_W'(1);
                    fb_next    = fb_reg + IDX_W'(m_reg) + IDX_W'(1);
                    state_next = ST_P_START;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (x_reg > x_sat_hi)
                    begin
                        sample_out_next = SMP_W'(x_sat_hi);
                        saturated_next  = 1'b1;
                    end
                    else if (x_reg < x_sat_lo)
                    begin
                        sample_out_next = SMP_W'(x_sat_lo);
                        saturated_next  = 1'b1;
                    end
                    else
                    begin
                        sample_out_next = SMP_W'(x_reg);
                        saturated_next  = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_ok_reg     <= in_range(rd_addr) && valid_reg[rd_addr[RAM_AW-1:0]];
            if (in_acc && (func == FUNC_CLEAR))
                valid_reg <= '0;
            else if (ram_we)
                valid_reg[wr_addr[RAM_AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_kind_reg  <= 1'b0;
            warp_alpha_reg   <= ALPHA_W'(576717);
            pade_order_reg   <= 3'd4;
            stage_count_reg  <= 4'd1;
            order_in_use_reg <= 5'd24;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_KIND: filter_kind_reg  <= cfg_data[0];
                CFG_WARP_ALPHA:  warp_alpha_reg   <= $signed(cfg_data[ALPHA_W-1:0]);
                CFG_PADE_ORDER:  pade_order_reg   <= cfg_data[2:0];
                CFG_STAGE_COUNT: stage_count_reg  <= cfg_data[3:0];
                CFG_ORDER_USE:   order_in_use_reg <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= ORDER; i++)
                coef_reg[i] <= '0;
        end
        else if (in_acc && (func == FUNC_CLEAR))
        begin
            for (int i = 0; i <= ORDER; i++)
                coef_reg[i] <= '0;
        end
        else if (in_acc && (func == FUNC_LOAD) && (32'(coef_index) <= ORDER))
        begin
            coef_reg[CI_W'(coef_index)] <= coef_value;
        end
    end

    always_ff @(posedge clk)
    begin
        aa_reg         <= aa_next;
        x_reg          <= x_next;
        acc_reg        <= acc_next;
        y_reg          <= y_next;
        t_reg          <= t_next;
        prev_reg       <= prev_next;
        sec_reg        <= sec_next;
        ptr_reg        <= ptr_next;
        fb_reg         <= fb_next;
        pt2_reg        <= pt2_next;
        ci_reg         <= ci_next;
        cnt_reg        <= cnt_next;
        m_reg          <= m_next;
        pd5_reg        <= pd5_next;
        n_reg          <= n_next;
        prod_reg       <= prod_next;
        sample_out_reg <= sample_out_next;
        saturated_reg  <= saturated_next;
    end

`ifndef ASSERT_OFF
    a_filter_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (func == FUNC_FILTER)) |=> (state_reg == ST_AA))
        else $error("filter transaction did not start the sequencer");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("finished result not presented");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("delay memory written while idle");
`endif

endmodule
